[rtl/tet_pkg.sv]
package tet_pkg;

	localparam int COORD_BITS = 12;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [1:0] {
		ACT_POLL     = 2'd0,
		ACT_MOVE_REQ = 2'd1,
		ACT_INJECT   = 2'd2,
		ACT_READ     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		K_DOWN         = 3'd0,
		K_UP           = 3'd1,
		K_MOVE         = 3'd2,
		K_MOVE_REPLY   = 3'd3,
		K_CACHED_REPLY = 3'd4
	} kind_t;

	localparam logic [1:0] PH_MOVE = 2'd2;

	// One result entry as it travels through the queue
	typedef struct packed {
		kind_t  kind;
		logic   contact;
		coord_t x;
		coord_t y;
		logic   last;
	} res_t;

	// Results produced by one accepted transaction (zero, one or two)
	typedef struct packed {
		logic [1:0] count;
		res_t       e0;
		res_t       e1;
	} push_t;

endpackage

[rtl/tet_front.sv]
module tet_front import tet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  action_t    action,
	input  logic       touching,
	input  coord_t     point_x,
	input  coord_t     point_y,
	input  logic [1:0] inject_phase,
	output push_t      push
);

	logic   prev_t_q, held_q, cached_t_q, move_pend_q;
	coord_t prev_x_q, prev_y_q, held_x_q, held_y_q;
	coord_t cached_x_q, cached_y_q, move_x_q, move_y_q;

	logic   prev_t_d, held_d, cached_t_d, move_pend_d;
	coord_t prev_x_d, prev_y_d, held_x_d, held_y_d;
	coord_t cached_x_d, cached_y_d, move_x_d, move_y_d;

	coord_t sx, sy;
	push_t  res;

	// A poll without contact takes the last touching coordinates
	assign sx = touching ? point_x : prev_x_q;
	assign sy = touching ? point_y : prev_y_q;

	// Classify the transaction and work out the next tracker state
	always_comb begin
		prev_t_d    = prev_t_q;
		prev_x_d    = prev_x_q;
		prev_y_d    = prev_y_q;
		held_d      = held_q;
		held_x_d    = held_x_q;
		held_y_d    = held_y_q;
		cached_t_d  = cached_t_q;
		cached_x_d  = cached_x_q;
		cached_y_d  = cached_y_q;
		move_x_d    = move_x_q;
		move_y_d    = move_y_q;
		move_pend_d = move_pend_q;
		res         = '0;
		res.e0.last = 1'b1;
		res.e1.last = 1'b1;
		unique case (action)
			ACT_POLL: begin
				if (touching && !prev_t_q && !held_q) begin
					// first touching sample: hold the down for one poll
					held_d     = 1'b1;
					held_x_d   = sx;
					held_y_d   = sy;
					cached_t_d = 1'b1;
					cached_x_d = sx;
					cached_y_d = sy;
				end else if (held_q) begin
					held_d = 1'b0;
					if (touching) begin
						res.count  = 2'd1;
						res.e0     = '{K_DOWN, 1'b1, sx, sy, 1'b1};
						cached_t_d = 1'b1;
						cached_x_d = sx;
						cached_y_d = sy;
						prev_t_d   = 1'b1;
						prev_x_d   = sx;
						prev_y_d   = sy;
					end else begin
						// short tap: down and up from the held sample
						res.count  = 2'd2;
						res.e0     = '{K_DOWN, 1'b1, held_x_q, held_y_q, 1'b0};
						res.e1     = '{K_UP, 1'b0, held_x_q, held_y_q, 1'b1};
						cached_t_d = 1'b0;
						cached_x_d = held_x_q;
						cached_y_d = held_y_q;
						prev_t_d   = 1'b0;
					end
				end else begin
					if (touching && !prev_t_q) begin
						res.count = 2'd1;
						res.e0    = '{K_DOWN, 1'b1, sx, sy, 1'b1};
					end else if (!touching && prev_t_q) begin
						res.count = 2'd1;
						res.e0    = '{K_UP, 1'b0, sx, sy, 1'b1};
					end else if (touching && (sx != prev_x_q || sy != prev_y_q)) begin
						move_x_d = sx;
						move_y_d = sy;
						if (!move_pend_q) begin
							move_pend_d = 1'b1;
							res.count   = 2'd1;
							res.e0      = '{K_MOVE, 1'b1, sx, sy, 1'b1};
						end
					end
					cached_t_d = touching;
					cached_x_d = sx;
					cached_y_d = sy;
					prev_t_d   = touching;
					if (touching) begin
						prev_x_d = sx;
						prev_y_d = sy;
					end
				end
			end
			ACT_MOVE_REQ: begin
				move_pend_d = 1'b0;
				res.count   = 2'd1;
				res.e0      = '{K_MOVE_REPLY, 1'b0, move_x_q, move_y_q, 1'b1};
			end
			ACT_INJECT: begin
				// unknown phase is dropped without effect
				if (inject_phase <= PH_MOVE) begin
					cached_t_d  = touching;
					cached_x_d  = point_x;
					cached_y_d  = point_y;
					move_x_d    = point_x;
					move_y_d    = point_y;
					move_pend_d = (inject_phase == PH_MOVE);
					res.count   = 2'd1;
					res.e0      = '{kind_t'({1'b0, inject_phase}), touching,
						point_x, point_y, 1'b1};
				end
			end
			ACT_READ: begin
				res.count = 2'd1;
				res.e0    = '{K_CACHED_REPLY, cached_t_q, cached_x_q, cached_y_q, 1'b1};
			end
			default: begin
				res.count = 2'd0;
			end
		endcase
	end

	// Tracker state, updated once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_t_q    <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			held_q      <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
			cached_t_q  <= 1'b0;
			cached_x_q  <= '0;
			cached_y_q  <= '0;
			move_x_q    <= '0;
			move_y_q    <= '0;
			move_pend_q <= 1'b0;
		end else if (accept) begin
			prev_t_q    <= prev_t_d;
			prev_x_q    <= prev_x_d;
			prev_y_q    <= prev_y_d;
			held_q      <= held_d;
			held_x_q    <= held_x_d;
			held_y_q    <= held_y_d;
			cached_t_q  <= cached_t_d;
			cached_x_q  <= cached_x_d;
			cached_y_q  <= cached_y_d;
			move_x_q    <= move_x_d;
			move_y_q    <= move_y_d;
			move_pend_q <= move_pend_d;
		end
	end

	// Results leave only with an accepted transaction
	always_comb begin
		push = res;
		if (!accept) begin
			push.count = 2'd0;
		end
	end

endmodule

[rtl/tet_queue.sv]
module tet_queue import tet_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  push_t                push,
	input  logic                 pop,
	output res_t                 head,
	output logic [QCNT_BITS-1:0] count
);

	res_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic [QPTR_BITS-1:0] wr_p1;

	assign wr_p1 = wr_q + QPTR_BITS'(1);
	assign head  = mem[rd_q];
	assign count = cnt_q;

	// Entry storage: up to two writes per cycle
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.e0;
		end
		if (push.count == 2'd2) begin
			mem[wr_p1] <= push.e1;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_BITS'(push.count);
			rd_q  <= rd_q + QPTR_BITS'(pop);
			cnt_q <= cnt_q + QCNT_BITS'(push.count) - QCNT_BITS'(pop);
		end
	end

endmodule

[rtl/tet_back.sv]
module tet_back import tet_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  res_t                 head,
	input  logic [QCNT_BITS-1:0] count,
	output logic                 pop,
	input  logic                 out_ready,
	output logic                 out_valid,
	output res_t                 out_res
);

	logic valid_q;
	res_t data_q;

	// Refill the output register when it is empty or being drained
	assign pop       = (count != '0) && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= (count != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

endmodule

[rtl/touch_event_tracker.sv]
// Touch event tracker: turns polled panel samples and host requests into down, up and
// move events and replies. One transaction is accepted per clock while at least two
// queue slots are free; the tracker state updates in that same cycle, so back-to-back
// transactions run at one per cycle. The output register holds one result at a time,
// so a short tap (down plus up) occupies it for two results in turn; the four-entry result
// queue between the classifier and the output register absorbs this, and input ready
// drops only when the queue holds more than two entries. The first result is written
// into the queue, then loaded into the output register when that register is free.
module touch_event_tracker import tet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic       touching,
	input  coord_t     point_x,
	input  coord_t     point_y,
	input  logic [1:0] inject_phase,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] kind,
	output logic       contact,
	output coord_t     out_x,
	output coord_t     out_y,
	output logic       last_of_run
);

	logic                 accept;
	push_t                push;
	logic                 pop;
	res_t                 head;
	res_t                 out_res;
	logic [QCNT_BITS-1:0] count;

	// Room for the worst case of two results
	assign in_ready = (count <= QCNT_BITS'(QUEUE_DEPTH - 2));
	assign accept   = in_valid && in_ready;

	tet_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.action       (action_t'(action)),
		.touching     (touching),
		.point_x      (point_x),
		.point_y      (point_y),
		.inject_phase (inject_phase),
		.push         (push)
	);

	tet_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	tet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.count     (count),
		.pop       (pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign kind        = out_res.kind;
	assign contact     = out_res.contact;
	assign out_x       = out_res.x;
	assign out_y       = out_res.y;
	assign last_of_run = out_res.last;

	// Queue never overfills
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// Results are only produced by an accepted transaction
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> accept)
		else $error("results pushed without an accepted transaction");

	// Only a poll can produce two results
	a_pair_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (action == ACT_POLL))
		else $error("result pair from a non-poll transaction");

	// Requests for the move point or cached sample always get exactly one reply
	a_reply_single: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (action == ACT_MOVE_REQ || action == ACT_READ)) |-> (push.count == 2'd1))
		else $error("request without a single reply");

endmodule
